FILE: sv/bit_pkg.sv
`default_nettype none
package bit_pkg;
    localparam int MaxDim  = 64;
    localparam int RowW    = 64;
    localparam int IdxW    = 6;
    localparam int CntW    = 7;
    localparam int CfgW    = 7;

    localparam logic CfgNumRows = 1'b0;
    localparam logic CfgNumCols = 1'b1;

    // Three-row window and sub-iteration flag handed to the row of cells
    typedef struct packed {
        logic [RowW-1:0] up;
        logic [RowW-1:0] mid;
        logic [RowW-1:0] dn;
        logic            second;
    } t_win;

    // Zhang-Suen removal test for one pixel, neighbors in ring order N..NW
    function automatic logic zs_remove(input logic p, input logic [7:0] nb,
                                       input logic second);
        logic [3:0] cnt;
        logic [3:0] trans;
        logic       p1;
        logic       p2;
        cnt   = '0;
        trans = '0;
        for (int k = 0; k < 8; k++) begin
            cnt = cnt + {3'b000, nb[k]};
            if (!nb[k] && nb[(k + 1) % 8]) begin
                trans = trans + 4'd1;
            end
        end
        if (second) begin
            p1 = nb[0] & nb[2] & nb[6];
            p2 = nb[0] & nb[4] & nb[6];
        end else begin
            p1 = nb[0] & nb[2] & nb[4];
            p2 = nb[2] & nb[4] & nb[6];
        end
        return p && trans == 4'd1 && cnt >= 4'd2 && cnt <= 4'd6 && !p1 && !p2;
    endfunction
endpackage
`default_nettype wire

FILE: sv/bit_cell.sv
`default_nettype none
// One pixel column cell: evaluates removal of its pixel for the row in the window.
module bit_cell (
    input  wire logic       i_p,
    input  wire logic [7:0] i_nb,
    input  wire logic       i_second,
    output logic            o_keep
);
    assign o_keep = i_p & ~bit_pkg::zs_remove(i_p, i_nb, i_second);
endmodule
`default_nettype wire

FILE: sv/bit_ram.sv
`default_nettype none
module bit_ram #(
    parameter int Width = 64,
    parameter int Depth = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(Depth)-1:0] i_waddr,
    input  wire logic [Width-1:0]         i_wdata,
    input  wire logic [$clog2(Depth)-1:0] i_raddr,
    output logic      [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

FILE: sv/bit_row.sv
`default_nettype none
// Row of column cells; output row is the thinned middle row of the window.
module bit_row (
    input  wire bit_pkg::t_win             i_win,
    input  wire logic [bit_pkg::RowW-1:0] i_mask,
    output logic      [bit_pkg::RowW-1:0] o_row
);
    localparam int W = bit_pkg::RowW;
    logic [W+1:0] w_u;
    logic [W+1:0] w_m;
    logic [W+1:0] w_d;
    assign w_u = {1'b0, i_win.up & i_mask, 1'b0};
    assign w_m = {1'b0, i_win.mid & i_mask, 1'b0};
    assign w_d = {1'b0, i_win.dn & i_mask, 1'b0};

    for (genvar c = 0; c < W; c++) begin : g_cell
        bit_cell u_cell (
            .i_p     (w_m[c+1]),
            .i_nb    ({w_u[c], w_m[c], w_d[c], w_d[c+1], w_d[c+2], w_m[c+2],
                       w_u[c+2], w_u[c+1]}),
            .i_second(i_win.second),
            .o_keep  (o_row[c])
        );
    end
endmodule
`default_nettype wire

FILE: sv/binary_image_thinning_unit.sv
`default_nettype none
// Zhang-Suen thinning of a binary image of up to 64x64 pixels. Rows enter one
// per transaction on s_axis (bit j = pixel j); the frame completes on row
// num_rows. Each sub-iteration sweeps the rows through a 64-cell column row
// (one row per cycle, through the RAM read and the window registers),
// ping-ponging between two row memories; passes repeat until one removes
// nothing. Then num_rows rows leave on m_axis, tlast on the final row; each
// row is read out only once the previous one has been accepted. Loading is
// one row per cycle while the unit is in its load state.
module binary_image_thinning_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_idx,
    input  wire logic [6:0]  i_cfg_wdata,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [63:0] s_axis_tdata,   // row_pixels
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic      [63:0] m_axis_tdata,   // thinned_row
    output logic             m_axis_tlast    // last_row
);
    localparam int W  = bit_pkg::RowW;
    localparam int IW = bit_pkg::IdxW;
    localparam int CW = bit_pkg::CntW;

    typedef enum logic [2:0] {S_LOAD, S_SWEEP, S_OUT, S_OWAIT} t_state;

    t_state r_state;
    logic [bit_pkg::CfgW-1:0] r_num_rows, r_num_cols;
    logic [CW-1:0] r_loaded;
    logic          r_bank;      // bank holding the current image
    logic          r_second;
    logic          r_changed;
    logic [CW-1:0] r_rd;        // read row pointer
    logic [CW+1:0] r_step;      // sweep step
    logic [W-1:0]  r_u, r_m, r_d;
    logic [W-1:0]  r_mask;
    logic          r_ovalid;
    logic [W-1:0]  r_odata;
    logic          r_olast;
    logic [CW-1:0] r_orow;

    // effective dimensions
    logic [CW-1:0] w_nr, w_nc;
    always_comb begin
        w_nr = (r_num_rows == '0) ? CW'(1) :
               (r_num_rows > CW'(bit_pkg::MaxDim)) ? CW'(bit_pkg::MaxDim) : r_num_rows;
        w_nc = (r_num_cols == '0) ? CW'(1) :
               (r_num_cols > CW'(bit_pkg::MaxDim)) ? CW'(bit_pkg::MaxDim) : r_num_cols;
    end
    logic [W-1:0] w_mask;
    assign w_mask = (w_nc[6]) ? '1 : ((W'(1) << w_nc[IW-1:0]) - W'(1));

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_rows <= 7'd64;
            r_num_cols <= 7'd64;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == bit_pkg::CfgNumRows) r_num_rows <= i_cfg_wdata;
            else                                  r_num_cols <= i_cfg_wdata;
        end
    end

    // two row banks
    logic [W-1:0] w_rd0, w_rd1, w_rdata, w_wdata, w_thin;
    logic         w_we0, w_we1;
    logic [IW-1:0] w_waddr, w_raddr;
    logic         w_s_acc, w_sweep_wr;
    logic [CW-1:0] w_wrow;

    assign w_s_acc  = s_axis_tvalid && s_axis_tready;
    assign w_raddr  = r_rd[IW-1:0];
    assign w_rdata  = r_bank ? w_rd1 : w_rd0;
    // sweep: step k reads row k; it passes the RAM output register, r_d and r_m before its cell output is written
    assign w_wrow   = CW'(r_step - (CW+2)'(3));
    assign w_sweep_wr = (r_state == S_SWEEP) && r_step >= (CW+2)'(3)
                        && w_wrow < w_nr;
    assign w_waddr  = (r_state == S_LOAD) ? r_loaded[IW-1:0] : w_wrow[IW-1:0];
    assign w_wdata  = (r_state == S_LOAD) ? s_axis_tdata : w_thin;
    assign w_we0 = (r_state == S_LOAD) ? (w_s_acc && !r_loaded[6] && !r_bank)
                                       : (w_sweep_wr && r_bank);
    assign w_we1 = (r_state == S_LOAD) ? (w_s_acc && !r_loaded[6] && r_bank)
                                       : (w_sweep_wr && !r_bank);

    bit_ram #(.Width(W), .Depth(bit_pkg::MaxDim)) u_ram0 (
        .i_clk(i_clk), .i_we(w_we0), .i_waddr(w_waddr), .i_wdata(w_wdata),
        .i_raddr(w_raddr), .o_rdata(w_rd0));
    bit_ram #(.Width(W), .Depth(bit_pkg::MaxDim)) u_ram1 (
        .i_clk(i_clk), .i_we(w_we1), .i_waddr(w_waddr), .i_wdata(w_wdata),
        .i_raddr(w_raddr), .o_rdata(w_rd1));

    bit_pkg::t_win w_win;
    assign w_win.up = r_u;
    assign w_win.mid = r_m;
    assign w_win.dn = r_d;
    assign w_win.second = r_second;

    bit_row u_row (.i_win(w_win), .i_mask(r_mask), .o_row(w_thin));

    // incoming row into the window, zero beyond image
    logic [CW+1:0] w_inrow;
    logic [W-1:0]  w_newd;
    assign w_inrow = r_step - (CW+2)'(1);
    assign w_newd  = (r_step >= (CW+2)'(1) && w_inrow < (CW+2)'(w_nr)) ? w_rdata : '0;

    // row changed by this write, last write of the sub-iteration
    logic w_row_diff, w_sweep_done;
    assign w_row_diff   = (w_thin ^ (r_m & r_mask)) != '0;
    assign w_sweep_done = w_sweep_wr && (w_wrow == w_nr - CW'(1));

    logic w_o_acc;
    assign w_o_acc = m_axis_tvalid && m_axis_tready;
    assign s_axis_tready = (r_state == S_LOAD);

    // control and datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_LOAD;
            r_loaded  <= '0;
            r_bank    <= 1'b0;
            r_second  <= 1'b0;
            r_changed <= 1'b0;
            r_rd      <= '0;
            r_step    <= '0;
            r_ovalid  <= 1'b0;
            r_orow    <= '0;
        end else begin
            case (r_state)
                S_LOAD: begin
                    if (w_o_acc) r_ovalid <= 1'b0;
                    if (w_s_acc) begin
                        if (r_loaded + CW'(1) >= w_nr) begin
                            r_state   <= S_SWEEP;
                            r_step    <= '0;
                            r_rd      <= '0;
                            r_second  <= 1'b0;
                            r_changed <= 1'b0;
                            r_mask    <= w_mask;
                        end
                        r_loaded <= (r_loaded == 7'd127) ? r_loaded : r_loaded + CW'(1);
                    end
                end
                S_SWEEP: begin
                    if (w_o_acc) r_ovalid <= 1'b0;
                    r_u <= (r_step == '0) ? '0 : r_m;
                    r_m <= (r_step == '0) ? '0 : r_d;
                    r_d <= w_newd;
                    if (w_sweep_done) begin
                        r_bank <= ~r_bank;
                        r_step <= '0;
                        r_rd   <= '0;
                        if (r_second) begin
                            r_second  <= 1'b0;
                            r_changed <= 1'b0;
                            if (!(r_changed || w_row_diff)) begin
                                r_state <= S_OUT;
                                r_orow  <= '0;
                            end
                        end else begin
                            r_second <= 1'b1;
                            if (w_row_diff) r_changed <= 1'b1;
                        end
                    end else begin
                        if (w_sweep_wr && w_row_diff) r_changed <= 1'b1;
                        r_rd   <= (r_rd + CW'(1) < w_nr) ? r_rd + CW'(1) : r_rd;
                        r_step <= r_step + (CW+2)'(1);
                    end
                end
                S_OUT: begin
                    // read issued at r_rd, data next cycle
                    r_rd <= r_orow;
                    if (!r_ovalid || w_o_acc) begin
                        r_ovalid <= 1'b0;
                        r_state  <= S_OWAIT;
                    end
                end
                S_OWAIT: begin
                    r_ovalid <= 1'b1;
                    r_odata  <= w_rdata & r_mask;
                    r_olast  <= (r_orow == w_nr - CW'(1));
                    if (r_orow == w_nr - CW'(1)) begin
                        r_state  <= S_LOAD;
                        r_loaded <= '0;
                        r_rd     <= r_orow;
                    end else begin
                        r_orow  <= r_orow + CW'(1);
                        r_state <= S_OUT;
                        r_rd    <= r_orow + CW'(1);
                    end
                end
                default: r_state <= S_LOAD;
            endcase
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;
    assign m_axis_tlast  = r_olast;

    // the row output must stay valid while stalled
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid && !m_axis_tready |=> r_ovalid)
        else $error("output row dropped");
    a_noload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_SWEEP |-> !s_axis_tready)
        else $error("load during sweep");
    a_wr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_we0 && w_we1))
        else $error("both banks written");
endmodule
`default_nettype wire

FILE: verif/tb.sv
`default_nettype none
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int QuietCycles = 24;
    localparam int CycleLimit  = 2000000;

    // one pending stimulus step: a row, a register write, or a drain pause
    typedef enum logic [1:0] {StepRow, StepCfg, StepDrain} t_step_kind;
    typedef struct {
        t_step_kind               kind;
        logic                     idx;
        logic [bit_pkg::CfgW-1:0] val;
        logic [bit_pkg::RowW-1:0] row;
    } t_step;

    typedef struct {
        logic [bit_pkg::RowW-1:0] row;
        logic                     last;
    } t_out_row;

    logic            i_clk;
    logic            i_rst_n;
    logic            i_cfg_we;
    logic            i_cfg_idx;
    logic [6:0]      i_cfg_wdata;
    logic            s_axis_tvalid;
    logic            s_axis_tready;
    logic [63:0]     s_axis_tdata;   // row_pixels
    logic            m_axis_tvalid;
    logic            m_axis_tready;
    logic [63:0]     m_axis_tdata;   // thinned_row
    logic            m_axis_tlast;   // last_row

    binary_image_thinning_unit DUT (.*);

    t_step    pending_steps[$];
    t_out_row expected_rows[$];

    // shadow of the block's state
    logic [bit_pkg::RowW-1:0] image_rows [bit_pkg::MaxDim];
    logic [bit_pkg::RowW-1:0] snap_rows  [bit_pkg::MaxDim];
    int                       rows_in_frame = 0;
    logic [bit_pkg::CfgW-1:0] cfg_rows = 7'd64;
    logic [bit_pkg::CfgW-1:0] cfg_cols = 7'd64;
    int                       act_rows;
    int                       act_cols;
    bit                       any_removed;

    int  errors = 0;
    int  frames_done;
    int  rows_checked;
    int  rows_sent;
    int  quiet;
    int  cycles = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int clamp_dim(logic [bit_pkg::CfgW-1:0] v);
        if (v == 0) return 1;
        if (v > bit_pkg::MaxDim) return bit_pkg::MaxDim;
        return int'(v);
    endfunction

    function automatic bit snap_px(int r, int c);
        if (r < 0 || r >= act_rows || c < 0 || c >= act_cols) return 1'b0;
        return snap_rows[r][c];
    endfunction

    // one sub-iteration: mark against a snapshot, then clear together
    function automatic void thin_half(bit second);
        bit [7:0] ring;
        int       links;
        int       fg;
        bit       q1;
        bit       q2;
        for (int r = 0; r < act_rows; r++) snap_rows[r] = image_rows[r];
        for (int r = 0; r < act_rows; r++) begin
            for (int c = 0; c < act_cols; c++) begin
                if (!snap_px(r, c)) continue;
                ring = {snap_px(r - 1, c - 1), snap_px(r, c - 1), snap_px(r + 1, c - 1),
                        snap_px(r + 1, c), snap_px(r + 1, c + 1), snap_px(r, c + 1),
                        snap_px(r - 1, c + 1), snap_px(r - 1, c)};
                links = 0;
                fg    = 0;
                for (int k = 0; k < 8; k++) begin
                    fg += ring[k];
                    if (!ring[k] && ring[(k + 1) % 8]) links++;
                end
                // ring bits: 0 N, 2 E, 4 S, 6 W
                q1 = second ? (ring[0] & ring[2] & ring[6]) : (ring[0] & ring[2] & ring[4]);
                q2 = second ? (ring[0] & ring[4] & ring[6]) : (ring[2] & ring[4] & ring[6]);
                if (links == 1 && fg >= 2 && fg <= 6 && !q1 && !q2) begin
                    image_rows[r][c] = 1'b0;
                    any_removed      = 1'b1;
                end
            end
        end
    endfunction

    // accept one row; on frame completion thin and queue the output rows
    function automatic void take_row(logic [bit_pkg::RowW-1:0] d);
        logic [bit_pkg::RowW-1:0] mask;
        t_out_row                 o;
        act_rows = clamp_dim(cfg_rows);
        act_cols = clamp_dim(cfg_cols);
        mask     = (act_cols >= 64) ? '1 : ((64'd1 << act_cols) - 64'd1);
        if (rows_in_frame < bit_pkg::MaxDim) image_rows[rows_in_frame] = d;
        if (rows_in_frame < 127) rows_in_frame++;
        if (rows_in_frame < act_rows) return;
        for (int r = 0; r < act_rows; r++) image_rows[r] &= mask;
        do begin
            any_removed = 1'b0;
            thin_half(1'b0);
            thin_half(1'b1);
        end while (any_removed);
        for (int r = 0; r < act_rows; r++) begin
            o.row  = image_rows[r] & mask;
            o.last = (r == act_rows - 1);
            expected_rows.push_back(o);
        end
        rows_in_frame = 0;
        frames_done++;
    endfunction

    // driver: bursts of rows with random gaps, register writes when idle
    int   burst_left;
    int   gap_left;
    logic nx_valid;
    logic [63:0] nx_data;
    logic nx_we;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            i_cfg_we      <= 1'b0;
            i_cfg_idx     <= 1'b0;
            i_cfg_wdata   <= '0;
            burst_left    = 0;
            gap_left      = 0;
            quiet         = 0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == bit_pkg::CfgNumRows) cfg_rows = i_cfg_wdata;
                else cfg_cols = i_cfg_wdata;
            end
            if (s_axis_tvalid && s_axis_tready) begin
                take_row(s_axis_tdata);
                rows_sent++;
            end
            if (expected_rows.size() == 0 && !m_axis_tvalid && !s_axis_tvalid && !i_cfg_we)
                quiet++;
            else
                quiet = 0;

            nx_valid = s_axis_tvalid && !s_axis_tready;
            nx_data  = s_axis_tdata;
            nx_we    = 1'b0;
            if (!nx_valid && pending_steps.size() > 0) begin
                case (pending_steps[0].kind)
                    StepCfg: begin
                        if (quiet >= QuietCycles) begin
                            nx_we = 1'b1;
                            i_cfg_idx   <= pending_steps[0].idx;
                            i_cfg_wdata <= pending_steps[0].val;
                            void'(pending_steps.pop_front());
                            quiet = 0;
                        end
                    end
                    StepDrain: begin
                        if (quiet >= QuietCycles) void'(pending_steps.pop_front());
                    end
                    default: begin
                        if (gap_left > 0) begin
                            gap_left--;
                        end else begin
                            nx_valid = 1'b1;
                            nx_data  = pending_steps[0].row;
                            void'(pending_steps.pop_front());
                            if (burst_left == 0) begin
                                burst_left = $urandom_range(1, 16);
                                gap_left   = ($urandom_range(0, 2) == 0) ? 0
                                                                         : $urandom_range(0, 6);
                            end else begin
                                burst_left--;
                            end
                        end
                    end
                endcase
            end
            s_axis_tvalid <= nx_valid;
            s_axis_tdata  <= nx_data;
            i_cfg_we      <= nx_we;
        end
    end

    // monitor: receiver stall pattern and result check
    int stall_mode;
    t_out_row want;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            stall_mode    = 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_rows.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected output row %h last %b", m_axis_tdata,
                                 m_axis_tlast);
                end else begin
                    want = expected_rows.pop_front();
                    rows_checked++;
                    if (want.row !== m_axis_tdata || want.last !== m_axis_tlast) begin
                        errors++;
                        if (errors <= 10)
                            $display("row mismatch: exp %h last %b, got %h last %b",
                                     want.row, want.last, m_axis_tdata, m_axis_tlast);
                    end
                end
            end
            if ($urandom_range(0, 299) == 0) stall_mode = $urandom_range(0, 3);
            case (stall_mode)
                0: m_axis_tready <= 1'b1;
                1: m_axis_tready <= ($urandom_range(0, 3) != 0);
                2: m_axis_tready <= ($urandom_range(0, 1) == 0);
                default: m_axis_tready <= (cycles % 5 < 2);
            endcase
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CycleLimit) begin
            $display("timeout after %0d cycles", cycles);
            $display("Verification failed");
            $finish;
        end
    end

    function automatic void add_cfg(logic idx, logic [bit_pkg::CfgW-1:0] val);
        t_step s;
        s.kind = StepCfg;
        s.idx  = idx;
        s.val  = val;
        s.row  = '0;
        pending_steps.push_back(s);
    endfunction

    function automatic void add_row(logic [bit_pkg::RowW-1:0] d);
        t_step s;
        s.kind = StepRow;
        s.idx  = 1'b0;
        s.val  = '0;
        s.row  = d;
        pending_steps.push_back(s);
    endfunction

    function automatic void add_drain();
        t_step s;
        s.kind = StepDrain;
        s.idx  = 1'b0;
        s.val  = '0;
        s.row  = '0;
        pending_steps.push_back(s);
    endfunction

    // random row with a density that varies from sparse to nearly solid
    function automatic logic [bit_pkg::RowW-1:0] rand_row(int dens);
        logic [bit_pkg::RowW-1:0] a;
        logic [bit_pkg::RowW-1:0] b;
        a = {$urandom, $urandom};
        b = {$urandom, $urandom};
        case (dens)
            0: return a & b;
            1: return a;
            2: return a | b;
            default: return a | b | {$urandom, $urandom};
        endcase
    endfunction

    int nr;
    int nc;
    int dens;
    int queued_rows;
    initial begin
        i_rst_n = 1'b0;

        // directed: 1x1 pixel, zero counts as one, solid blocks, shrink mid-frame
        add_cfg(bit_pkg::CfgNumRows, 7'd0);
        add_cfg(bit_pkg::CfgNumCols, 7'd0);
        add_row('1);
        add_cfg(bit_pkg::CfgNumRows, 7'd1);
        add_cfg(bit_pkg::CfgNumCols, 7'd64);
        add_row('1);
        add_cfg(bit_pkg::CfgNumRows, 7'd4);
        add_cfg(bit_pkg::CfgNumCols, 7'd8);
        repeat (4) add_row(64'hFF);
        add_cfg(bit_pkg::CfgNumRows, 7'd5);
        add_cfg(bit_pkg::CfgNumCols, 7'd6);
        add_row(64'h0);
        add_row(64'h1E);
        add_row(64'h3F);
        add_row(64'h1E);
        add_row(64'hFFFF_FFFF_FFFF_FFC0);
        // row count shrinks below rows already loaded
        add_cfg(bit_pkg::CfgNumRows, 7'd8);
        add_cfg(bit_pkg::CfgNumCols, 7'd16);
        repeat (5) add_row(64'hFFFF);
        add_cfg(bit_pkg::CfgNumRows, 7'd3);
        add_row(64'h0F0F);
        // column count changes mid-frame, values above range clamp
        add_cfg(bit_pkg::CfgNumRows, 7'd3);
        add_row(64'h5555_5555_5555_5555);
        add_cfg(bit_pkg::CfgNumCols, 7'd127);
        add_row('1);
        add_row(64'hAAAA_AAAA_AAAA_AAAA);
        add_drain();

        // random frames, mostly small, a few at full size
        queued_rows = 0;
        while (queued_rows < 310) begin
            nr   = ($urandom_range(0, 9) == 0) ? 64 : $urandom_range(1, 16);
            nc   = ($urandom_range(0, 7) == 0) ? 64 : $urandom_range(1, 64);
            dens = $urandom_range(0, 3);
            if ($urandom_range(0, 5) == 0) nr = 65 + $urandom_range(0, 62);
            add_cfg(bit_pkg::CfgNumRows, nr[bit_pkg::CfgW-1:0]);
            add_cfg(bit_pkg::CfgNumCols, nc[bit_pkg::CfgW-1:0]);
            repeat (clamp_dim(nr[bit_pkg::CfgW-1:0])) begin
                add_row(rand_row(dens));
                queued_rows++;
            end
            if ($urandom_range(0, 7) == 0) add_drain();
        end

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        wait (pending_steps.size() == 0);
        @(posedge i_clk);
        while (s_axis_tvalid || expected_rows.size() != 0 || quiet < QuietCycles)
            @(posedge i_clk);

        $display("%0d rows sent in %0d frames, %0d output rows checked, %0d errors",
                 rows_sent, frames_done, rows_checked, errors);
        $display("frames ranged from 1x1 to 64x64 with zero and oversize registers");
        if (errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule
`default_nettype wire
